// File: rtl/tas_pkg.sv
// Shared types, constants and tables for the thruster allocation block.
package tas_pkg;

    localparam int NUM_ACTUATORS = 8;
    localparam int NUM_AXES      = 6;
    localparam int COEF_DEPTH    = NUM_AXES * NUM_ACTUATORS;
    localparam int COEF_AW       = 6;
    localparam int ACT_W         = 3;
    localparam int AX_W          = 3;
    localparam int CNT_W         = 4;
    localparam int VEC_W         = 18;
    localparam int PROD_W        = 34;
    localparam int ACC_W         = 40;

    localparam logic FUNC_CMD   = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [15:0] UNSET_MARK  = 16'h8000;
    localparam logic [15:0] CUTOFF_ONE  = 16'd4096;
    localparam logic [15:0] QUARTER     = 16'h4000;
    localparam logic [CNT_W-1:0] ACT_RESET = CNT_W'(NUM_ACTUATORS);

    // round(16384*sin(k*pi/64)), k = 0..32
    localparam logic [14:0] SINE_TABLE [33] = '{
        15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,
        15'd4756,  15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,
        15'd9102,  15'd9760,  15'd10394, 15'd11003, 15'd11585, 15'd12140,
        15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
        15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207,
        15'd16305, 15'd16364, 15'd16384
    };

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_SIN_MUL,
        OP_SIN_FIN,
        OP_RMUL,
        OP_RACC,
        OP_MAC,
        OP_FIN
    } tas_op_e;

    typedef struct packed {
        logic        func;
        logic [15:0] force_x;
        logic [15:0] force_y;
        logic [15:0] force_z;
        logic [15:0] torque_x;
        logic [15:0] torque_y;
        logic [15:0] torque_z;
        logic [15:0] roll_angle;
        logic [15:0] pitch_angle;
        logic [5:0]  table_address;
        logic [15:0] table_value;
    } tas_in_t;

    typedef struct packed {
        logic [2:0]  actuator_index;
        logic [15:0] actuator_target;
        logic        last_actuator;
    } tas_out_t;

    typedef struct packed {
        tas_op_e          op;
        logic [2:0]       sel;
        logic [ACT_W-1:0] act;
        logic             first;
        logic             last;
    } tas_cmd_t;

    typedef struct packed {
        logic out_free;
    } tas_sts_t;

    function automatic logic [15:0] unset_to_zero(input logic [15:0] v);
        return (v == UNSET_MARK) ? 16'd0 : v;
    endfunction

endpackage

// File: rtl/tas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tas_ctrl.sv
// Sequencer for the allocation block: issues one datapath command per cycle.
module tas_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tas_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_func,
    output logic                      s_ready,
    output tas_pkg::tas_cmd_t         cmd,
    input  tas_pkg::tas_sts_t         sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIN,
        S_ROT,
        S_MAC,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                        state_reg;
    logic [3:0]                    step_reg;
    logic [tas_pkg::ACT_W-1:0]     act_reg;
    logic [tas_pkg::AX_W-1:0]      ax_reg;
    logic                          drain_reg;
    logic [tas_pkg::CNT_W-1:0]     count_reg;
    logic [tas_pkg::CNT_W-1:0]     count_eff;
    logic                          last_act;

    always_comb begin
        if (count_reg == '0) begin
            count_eff = tas_pkg::CNT_W'(1);
        end else if (count_reg > tas_pkg::CNT_W'(tas_pkg::NUM_ACTUATORS)) begin
            count_eff = tas_pkg::CNT_W'(tas_pkg::NUM_ACTUATORS);
        end else begin
            count_eff = count_reg;
        end
    end

    assign last_act = ((tas_pkg::CNT_W'(act_reg) + tas_pkg::CNT_W'(1)) == count_eff);
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        cmd       = '0;
        cmd.op    = tas_pkg::OP_NONE;
        cmd.act   = act_reg;
        cmd.last  = last_act;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = (s_func == tas_pkg::FUNC_WRITE) ? tas_pkg::OP_WRITE
                                                              : tas_pkg::OP_LOAD;
                end
            end
            S_SIN: begin
                cmd.op  = step_reg[0] ? tas_pkg::OP_SIN_FIN : tas_pkg::OP_SIN_MUL;
                cmd.sel = {1'b0, step_reg[2:1]};
            end
            S_ROT: begin
                cmd.op  = step_reg[0] ? tas_pkg::OP_RACC : tas_pkg::OP_RMUL;
                cmd.sel = step_reg[3:1];
            end
            S_MAC: begin
                cmd.op    = tas_pkg::OP_MAC;
                cmd.sel   = ax_reg;
                cmd.first = (ax_reg == '0);
            end
            S_DRAIN: begin
                cmd.op = tas_pkg::OP_NONE;
            end
            S_FIN: begin
                cmd.op = tas_pkg::OP_FIN;
            end
            default: begin
                cmd.op = tas_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            act_reg   <= '0;
            ax_reg    <= '0;
            drain_reg <= 1'b0;
            count_reg <= tas_pkg::ACT_RESET;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    step_reg <= '0;
                    if (s_valid && (s_func == tas_pkg::FUNC_CMD)) begin
                        state_reg <= S_SIN;
                    end
                end
                S_SIN: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd7) begin
                        step_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15) begin
                        act_reg   <= '0;
                        ax_reg    <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (ax_reg == tas_pkg::AX_W'(tas_pkg::NUM_AXES - 1)) begin
                        drain_reg <= 1'b0;
                        state_reg <= S_DRAIN;
                    end else begin
                        ax_reg <= ax_reg + tas_pkg::AX_W'(1);
                    end
                end
                S_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (sts.out_free) begin
                        if (last_act) begin
                            state_reg <= S_IDLE;
                        end else begin
                            act_reg   <= act_reg + tas_pkg::ACT_W'(1);
                            ax_reg    <= '0;
                            state_reg <= S_MAC;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/tas_dp.sv
// Datapath: sine unit, attitude rotation, matrix multiply-accumulate, clamp, output register.
module tas_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  tas_pkg::tas_in_t   s_data,
    input  tas_pkg::tas_cmd_t  cmd,
    output tas_pkg::tas_sts_t  sts,
    output logic               m_valid,
    input  logic               m_ready,
    output tas_pkg::tas_out_t  m_data
);

    logic signed [15:0]                comp_reg [tas_pkg::NUM_AXES];
    logic [15:0]                       roll_reg;
    logic [15:0]                       pitch_reg;
    logic signed [15:0]                trig_reg [4];  // sin r, cos r, sin p, cos p
    logic [14:0]                       sin_base_reg;
    logic                              sin_neg_reg;
    logic signed [tas_pkg::PROD_W-1:0] prod_reg;
    logic signed [tas_pkg::PROD_W-1:0] racc_reg;
    logic signed [tas_pkg::VEC_W-1:0]  v_reg [3];
    logic signed [tas_pkg::VEC_W-1:0]  uz_reg;
    logic                              mac1_reg;
    logic                              first1_reg;
    logic [tas_pkg::AX_W-1:0]          ax1_reg;
    logic                              mac2_reg;
    logic                              first2_reg;
    logic signed [tas_pkg::ACC_W-1:0]  acc_reg;
    logic [tas_pkg::COEF_DEPTH-1:0]    coef_vld_reg;
    logic                              coef_vld_q_reg;
    logic [15:0]                       cutoff_reg [tas_pkg::NUM_ACTUATORS];
    logic                              out_valid_reg;
    tas_pkg::tas_out_t                 out_reg;

    // ---- table writes
    logic                        coef_we;
    logic                        cut_we;
    logic [tas_pkg::COEF_AW-1:0] cut_off;
    logic [15:0]                 cut_mag;
    logic [tas_pkg::COEF_AW-1:0] coef_raddr;
    logic [15:0]                 coef_rdata;

    assign coef_we = (cmd.op == tas_pkg::OP_WRITE) &&
                     (s_data.table_address < tas_pkg::COEF_AW'(tas_pkg::COEF_DEPTH));
    assign cut_off = s_data.table_address - tas_pkg::COEF_AW'(tas_pkg::COEF_DEPTH);
    assign cut_we  = (cmd.op == tas_pkg::OP_WRITE) && !coef_we &&
                     (cut_off < tas_pkg::COEF_AW'(tas_pkg::NUM_ACTUATORS));

    always_comb begin
        if (s_data.table_value == tas_pkg::UNSET_MARK) begin
            cut_mag = 16'd32767;
        end else if (s_data.table_value[15]) begin
            cut_mag = 16'd0 - s_data.table_value;
        end else begin
            cut_mag = s_data.table_value;
        end
    end

    assign coef_raddr = tas_pkg::COEF_AW'(cmd.sel) * tas_pkg::COEF_AW'(tas_pkg::NUM_ACTUATORS)
                      + tas_pkg::COEF_AW'(cmd.act);

    tas_ram #(
        .WIDTH (16),
        .DEPTH (tas_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (s_data.table_address),
        .wdata (s_data.table_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // ---- sine unit, front half
    logic [15:0] angle;
    logic [14:0] phase;
    logic [5:0]  sidx;
    logic [8:0]  sfrac;
    logic [5:0]  k_lo;
    logic [5:0]  k_hi;
    logic [14:0] sdelta;

    always_comb begin
        angle = cmd.sel[1] ? pitch_reg : roll_reg;
        if (cmd.sel[0]) begin
            angle = angle + tas_pkg::QUARTER;
        end
        phase = {1'b0, angle[13:0]};
        if (angle[14]) begin
            phase = 15'h4000 - phase;
        end
        sidx  = phase[14:9];
        sfrac = phase[8:0];
        k_lo  = sidx[5] ? 6'd32 : sidx;
        k_hi  = sidx[5] ? 6'd32 : sidx + 6'd1;
        sdelta = tas_pkg::SINE_TABLE[k_hi] - tas_pkg::SINE_TABLE[k_lo];
    end

    // ---- shared multiplier operands
    logic signed [tas_pkg::VEC_W-1:0] vec [tas_pkg::NUM_AXES];
    logic signed [15:0]               mul_a;
    logic signed [tas_pkg::VEC_W-1:0] mul_b;
    logic                             mul_en;

    always_comb begin
        vec[0] = v_reg[0];
        vec[1] = v_reg[1];
        vec[2] = v_reg[2];
        for (int i = 3; i < tas_pkg::NUM_AXES; i++) begin
            vec[i] = tas_pkg::VEC_W'(comp_reg[i]);
        end
    end

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        if (mac1_reg) begin
            mul_en = 1'b1;
            mul_a  = coef_vld_q_reg ? signed'(coef_rdata) : 16'sd0;
            mul_b  = vec[ax1_reg];
        end else if (cmd.op == tas_pkg::OP_SIN_MUL) begin
            mul_en = 1'b1;
            mul_a  = signed'({1'b0, sdelta});
            mul_b  = signed'(tas_pkg::VEC_W'(sfrac));
        end else if (cmd.op == tas_pkg::OP_RMUL) begin
            mul_en = 1'b1;
            case (cmd.sel)
                3'd0: begin mul_a = trig_reg[3]; mul_b = tas_pkg::VEC_W'(comp_reg[0]); end
                3'd1: begin mul_a = trig_reg[2]; mul_b = tas_pkg::VEC_W'(comp_reg[2]); end
                3'd2: begin mul_a = trig_reg[2]; mul_b = tas_pkg::VEC_W'(comp_reg[0]); end
                3'd3: begin mul_a = trig_reg[3]; mul_b = tas_pkg::VEC_W'(comp_reg[2]); end
                3'd4: begin mul_a = trig_reg[1]; mul_b = tas_pkg::VEC_W'(comp_reg[1]); end
                3'd5: begin mul_a = trig_reg[0]; mul_b = uz_reg; end
                3'd6: begin mul_a = trig_reg[1]; mul_b = uz_reg; end
                default: begin mul_a = trig_reg[0]; mul_b = tas_pkg::VEC_W'(comp_reg[1]); end
            endcase
        end
    end

    // ---- rotation pair finish: Q14 round half up
    logic signed [tas_pkg::PROD_W:0] rsum;
    logic signed [tas_pkg::PROD_W:0] rrnd;
    logic                            rsub;

    assign rsub = (cmd.sel == 3'd1) || (cmd.sel == 3'd7);
    always_comb begin
        if (rsub) begin
            rsum = (tas_pkg::PROD_W+1)'(racc_reg) - (tas_pkg::PROD_W+1)'(prod_reg);
        end else begin
            rsum = (tas_pkg::PROD_W+1)'(racc_reg) + (tas_pkg::PROD_W+1)'(prod_reg);
        end
        rrnd = (rsum + (tas_pkg::PROD_W+1)'(8192)) >>> 14;
    end

    // ---- sine finish
    logic [15:0] sval;
    assign sval = 16'(sin_base_reg) + prod_reg[24:9];

    // ---- actuator sum: Q24 to Q12, clamp to cut-off
    logic signed [tas_pkg::ACC_W-1:0]    arnd;
    logic signed [tas_pkg::ACC_W-13:0]   tval;
    logic signed [tas_pkg::ACC_W-13:0]   lim;
    logic signed [15:0]                  target;

    always_comb begin
        arnd = (acc_reg + tas_pkg::ACC_W'(2048)) >>> 12;
        tval = arnd[tas_pkg::ACC_W-13:0];
        lim  = signed'((tas_pkg::ACC_W-12)'(cutoff_reg[cmd.act]));
        if (tval > lim) begin
            target = lim[15:0];
        end else if (tval < -lim) begin
            target = 16'(-lim);
        end else begin
            target = tval[15:0];
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;

    // ---- payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == tas_pkg::OP_LOAD) begin
            comp_reg[0] <= signed'(tas_pkg::unset_to_zero(s_data.force_x));
            comp_reg[1] <= signed'(tas_pkg::unset_to_zero(s_data.force_y));
            comp_reg[2] <= signed'(tas_pkg::unset_to_zero(s_data.force_z));
            comp_reg[3] <= signed'(tas_pkg::unset_to_zero(s_data.torque_x));
            comp_reg[4] <= signed'(tas_pkg::unset_to_zero(s_data.torque_y));
            comp_reg[5] <= signed'(tas_pkg::unset_to_zero(s_data.torque_z));
            roll_reg    <= s_data.roll_angle;
            pitch_reg   <= s_data.pitch_angle;
        end
        if (cmd.op == tas_pkg::OP_SIN_MUL) begin
            sin_base_reg <= tas_pkg::SINE_TABLE[k_lo];
            sin_neg_reg  <= angle[15];
        end
        if (cmd.op == tas_pkg::OP_SIN_FIN) begin
            trig_reg[cmd.sel[1:0]] <= sin_neg_reg ? signed'(16'd0 - sval) : signed'(sval);
        end
        if (mul_en) begin
            prod_reg <= tas_pkg::PROD_W'(mul_a) * tas_pkg::PROD_W'(mul_b);
        end
        if (cmd.op == tas_pkg::OP_RACC) begin
            if (!cmd.sel[0]) begin
                racc_reg <= prod_reg;
            end else begin
                case (cmd.sel[2:1])
                    2'd0:    v_reg[0] <= rrnd[tas_pkg::VEC_W-1:0];
                    2'd1:    uz_reg   <= rrnd[tas_pkg::VEC_W-1:0];
                    2'd2:    v_reg[1] <= rrnd[tas_pkg::VEC_W-1:0];
                    default: v_reg[2] <= rrnd[tas_pkg::VEC_W-1:0];
                endcase
            end
        end
        ax1_reg        <= cmd.sel;
        first1_reg     <= cmd.first;
        first2_reg     <= first1_reg;
        coef_vld_q_reg <= coef_vld_reg[coef_raddr];
        if (mac2_reg) begin
            acc_reg <= (first2_reg ? tas_pkg::ACC_W'(0) : acc_reg)
                     + tas_pkg::ACC_W'(prod_reg);
        end
        if ((cmd.op == tas_pkg::OP_FIN) && sts.out_free) begin
            out_reg.actuator_index  <= cmd.act;
            out_reg.actuator_target <= target;
            out_reg.last_actuator   <= cmd.last;
        end
    end

    // ---- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac1_reg      <= 1'b0;
            mac2_reg      <= 1'b0;
            coef_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tas_pkg::NUM_ACTUATORS; i++) begin
                cutoff_reg[i] <= tas_pkg::CUTOFF_ONE;
            end
        end else begin
            mac1_reg <= (cmd.op == tas_pkg::OP_MAC);
            mac2_reg <= mac1_reg;
            if (coef_we) begin
                coef_vld_reg[s_data.table_address] <= 1'b1;
            end
            if (cut_we) begin
                cutoff_reg[cut_off[tas_pkg::ACT_W-1:0]] <= cut_mag;
            end
            if ((cmd.op == tas_pkg::OP_FIN) && sts.out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/thruster_allocation_saturate_core.sv
// Top level: six-axis command to clamped per-actuator targets.
// Flow: a command goes through sine lookup and attitude rotation, then, per actuator,
//   a multiply-accumulate issue per axis on the one shared multiplier, a pipeline
//   drain and a clamp step. Requests of either kind are taken only while idle, so a
//   new command waits until the last target of the previous one is clamped.
//   A held result stalls only at its clamp step.
// Reset: coefficients read as zero (per-entry valid bits), cut-offs 1.0, count 8.
module thruster_allocation_saturate_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tas_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tas_pkg::tas_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tas_pkg::tas_out_t         m_data
);

    // command from the sequencer, status back from the datapath
    tas_pkg::tas_cmd_t cmd;
    tas_pkg::tas_sts_t sts;

    // Sequencer: owns the actuator-count register and steps each command
    // through sine, rotation and the per-actuator accumulate loop.
    tas_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_func      (s_data.func),
        .s_ready     (s_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // Datapath: coefficient RAM, cut-off registers, shared multiplier and the
    // output register that decouples result hand-off from the next request.
    tas_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/thruster_allocation_saturate_checker.sv
// Checker: watches both request channels, predicts actuator targets and compares them.
`timescale 1ns / 100ps
module thruster_allocation_saturate_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  tas_pkg::tas_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  tas_pkg::tas_out_t m_data,
    output int                fail_count,
    output int                targets_pending
);

    logic signed [15:0] coef_mem [tas_pkg::COEF_DEPTH];
    logic        [15:0] cut_mem  [tas_pkg::NUM_ACTUATORS];
    logic        [3:0]  act_count;
    tas_pkg::tas_out_t  target_q [$];

    assign targets_pending = target_q.size();

    function automatic logic signed [31:0] sine_q14(input logic [15:0] ang);
        logic [1:0]  quad;
        logic [14:0] p;
        logic [5:0]  idx;
        logic [8:0]  frac;
        int          d, val;
        quad = ang[15:14];
        p    = {1'b0, ang[13:0]};
        if (quad[0]) p = 15'h4000 - p;
        idx  = p[14:9];
        frac = p[8:0];
        if (idx >= 32) begin
            val = 16384;
        end else begin
            d   = int'(tas_pkg::SINE_TABLE[idx+1]) - int'(tas_pkg::SINE_TABLE[idx]);
            val = int'(tas_pkg::SINE_TABLE[idx]) + ((d * int'(frac)) >>> 9);
        end
        return quad[1] ? -val : val;
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint axis_val(input logic [15:0] raw);
        return (raw == tas_pkg::UNSET_MARK) ? 0 : longint'($signed(raw));
    endfunction

    task automatic predict_targets(input tas_pkg::tas_in_t r);
        longint v [tas_pkg::NUM_AXES];
        longint fx, fy, fz, sr, cr, sp, cp, ux, uy, uz, acc, t, lim;
        int     n;
        tas_pkg::tas_out_t o;
        fx = axis_val(r.force_x);
        fy = axis_val(r.force_y);
        fz = axis_val(r.force_z);
        sr = sine_q14(r.roll_angle);
        cr = sine_q14(r.roll_angle + 16'h4000);
        sp = sine_q14(r.pitch_angle);
        cp = sine_q14(r.pitch_angle + 16'h4000);
        ux = rnd_shift(cp * fx - sp * fz, 14);
        uy = fy;
        uz = rnd_shift(sp * fx + cp * fz, 14);
        v[0] = ux;
        v[1] = rnd_shift(cr * uy + sr * uz, 14);
        v[2] = rnd_shift(cr * uz - sr * uy, 14);
        v[3] = axis_val(r.torque_x);
        v[4] = axis_val(r.torque_y);
        v[5] = axis_val(r.torque_z);
        n = (act_count == 0) ? 1 :
            (act_count > tas_pkg::NUM_ACTUATORS) ? tas_pkg::NUM_ACTUATORS : act_count;
        for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int i = 0; i < tas_pkg::NUM_AXES; i++)
                acc += v[i] * longint'(coef_mem[i*tas_pkg::NUM_ACTUATORS+j]);
            t   = rnd_shift(acc, 12);
            lim = longint'(cut_mem[j]);
            if (t > lim) t = lim;
            else if (t < -lim) t = -lim;
            o.actuator_index  = j[2:0];
            o.actuator_target = t[15:0];
            o.last_actuator   = (j == n - 1);
            target_q.push_back(o);
        end
    endtask

    task automatic store_write(input tas_pkg::tas_in_t r);
        int mag;
        if (r.table_address < tas_pkg::COEF_DEPTH) begin
            coef_mem[r.table_address] = $signed(r.table_value);
        end else if (r.table_address < tas_pkg::COEF_DEPTH + tas_pkg::NUM_ACTUATORS) begin
            mag = int'($signed(r.table_value));
            if (mag < 0) mag = -mag;
            if (mag > 32767) mag = 32767;
            cut_mem[r.table_address - tas_pkg::COEF_DEPTH] = mag[15:0];
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tas_pkg::COEF_DEPTH; i++) coef_mem[i] = '0;
            for (int i = 0; i < tas_pkg::NUM_ACTUATORS; i++) cut_mem[i] = tas_pkg::CUTOFF_ONE;
            act_count = 4'd8;
            target_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (target_q.size() == 0) begin
                    $error("unexpected target idx=%0d val=%h", m_data.actuator_index,
                           m_data.actuator_target);
                    fail_count++;
                end else begin
                    tas_pkg::tas_out_t e;
                    e = target_q.pop_front();
                    if (e.actuator_index !== m_data.actuator_index) begin
                        $error("actuator_index exp %0d got %0d", e.actuator_index,
                               m_data.actuator_index);
                        fail_count++;
                    end
                    if (e.actuator_target !== m_data.actuator_target) begin
                        $error("actuator_target exp %h got %h", e.actuator_target,
                               m_data.actuator_target);
                        fail_count++;
                    end
                    if (e.last_actuator !== m_data.last_actuator) begin
                        $error("last_actuator exp %0d got %0d", e.last_actuator,
                               m_data.last_actuator);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.func == tas_pkg::FUNC_CMD) predict_targets(s_data);
                else store_write(s_data);
            end
            if (cfg_wr_en) act_count = cfg_wr_data;
        end
    end
endmodule

// File: tb/thruster_allocation_saturate_core_tb.sv
// Testbench top: stimulus, idling phases and the verdict.
`timescale 1ns / 100ps
module thruster_allocation_saturate_core_tb;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   DRAIN_WAIT  = 120;   // longer than one eight-actuator command
    localparam int   HOLD_CYCLES = 600;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tas_pkg::tas_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tas_pkg::tas_out_t m_data;
    int       fail_count, targets_pending;
    int       send_idle_pct = 0;   // sender idle chance per cycle
    int       recv_stall_pct = 0;  // receiver stall chance per cycle
    logic     hold_req = 1'b0;     // ask the receiver for one long hold-off
    logic     hold_taken = 1'b0;
    int       hold_off = 0;        // long receiver hold-off, in cycles
    int       cycle_no = 0;

    always #10 aclk = ~aclk;

    thruster_allocation_saturate_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    thruster_allocation_saturate_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .targets_pending(targets_pending)
    );

    // Receiver: random stalls, or a counted long hold-off when asked.
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_off > 0) begin
            m_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Random 16-bit value biased towards the edges and the unset mark.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'h0000;
            4, 5: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one request, with optional random idle first; waits for acceptance.
    // Valid is left high afterwards; the next idle cycle or drain lowers it.
    task automatic send_request(input tas_pkg::tas_in_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_cmd(input logic [15:0] fx, fy, fz, tx, ty, tz, roll, pitch);
        tas_pkg::tas_in_t r;
        r = '0;
        r.func = tas_pkg::FUNC_CMD;
        r.force_x = fx; r.force_y = fy; r.force_z = fz;
        r.torque_x = tx; r.torque_y = ty; r.torque_z = tz;
        r.roll_angle = roll; r.pitch_angle = pitch;
        r.table_address = 6'($urandom); r.table_value = 16'($urandom);  // ignored
        send_request(r);
    endtask

    task automatic send_write(input logic [5:0] addr, input logic [15:0] val);
        tas_pkg::tas_in_t r;
        r = tas_pkg::tas_in_t'({$urandom, $urandom, $urandom, $urandom});  // junk fields
        r.func = tas_pkg::FUNC_WRITE;
        r.table_address = addr;
        r.table_value = val;
        send_request(r);
    endtask

    task automatic send_random_cmd();
        send_cmd(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), 16'($urandom), 16'($urandom));
    endtask

    // Wait until every target has arrived, then let the engine go quiet.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (targets_pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_actuators(input logic [3:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int pct_s [4];
        int pct_r [4];
        logic [3:0] counts [4];
        pct_s = '{0, 72, 0, 26};
        pct_r = '{0, 0, 72, 26};
        counts = '{4'd8, 4'd1, 4'd0, 4'd15};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: defaults (zero coefficients, cut-offs 1.0), then a loaded matrix.
        send_cmd(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000);
        for (int a = 0; a < 6; a++) send_write(6'(a * 8 + a), 16'h1000);
        send_write(6'd7, 16'h8000);
        send_write(6'd47, 16'h7FFF);
        send_write(6'd50, 16'h8000);   // cut-off of the unset mark saturates
        send_write(6'd51, 16'h0000);   // zero cut-off forces zero
        send_write(6'd52, 16'hF000);   // negative taken as magnitude
        send_write(6'd60, 16'h1234);   // unused address
        send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h0000, 16'h0000);
        send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h8000);
        send_cmd(16'h8001, 16'h0800, 16'hF800, 16'h8001, 16'h7FFF, 16'h0400,
                 16'h4000, 16'hC000);
        send_cmd(16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h0000, 16'h0000,
                 16'h2000, 16'hE000);
        send_cmd(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
                 16'hFFFF, 16'h0001);

        // Random phases, each under its own actuator count and idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            set_actuators(counts[ph]);
            send_idle_pct  = pct_s[ph];
            recv_stall_pct = pct_r[ph];
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(99) < 25)
                    send_write(6'($urandom_range(63)), rand_word());
                else
                    send_random_cmd();
                if (k == 20) drain();   // sender pauses until the pipe is empty
            end
        end

        // Long receiver hold-off while commands keep coming: block must backpressure.
        set_actuators(4'd3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        for (int k = 0; k < 12; k++) send_random_cmd();

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
